// ----- sv/cbm_pkg.sv -----
// Package for the cartridge bank mapper: item types, codes and constants.
// Used by every module of the block; depends on nothing.
package cbm_pkg;

	typedef enum logic [2:0] {
		KIND_REG_WRITE = 3'd0,
		KIND_EXP_WRITE = 3'd1,
		KIND_RAM_READ  = 3'd2,
		KIND_SCANLINE  = 3'd3,
		KIND_PRG_XLATE = 3'd4,
		KIND_CHR_XLATE = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		CFG_PRG_COUNT  = 3'd0,
		CFG_CHR_COUNT  = 3'd1,
		CFG_PROTECT    = 3'd2,
		CFG_FOUR_SCR   = 3'd3,
		CFG_RAM_PRES   = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] address;
		logic [7:0]  data;
		logic        rendering_on;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  bank_number;
		logic [7:0]  read_data;
		logic        read_from_ram;
		logic [12:0] ram_offset;
		logic        irq_line;
		logic        mirror_horizontal;
		logic        mirror_update;
	} out_word_t;

	// Start/done handshake with the shared modulo unit.
	typedef struct packed {
		logic       start;
		logic [7:0] dividend;
		logic [8:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] remainder;
	} mod_rsp_t;

	localparam logic [15:0] REG_ADDR_MASK = 16'hE001;
	localparam logic [15:0] REG_BANK_SEL  = 16'h8000;
	localparam logic [15:0] REG_BANK_DATA = 16'h8001;
	localparam logic [15:0] REG_MIRROR    = 16'hA000;
	localparam logic [15:0] REG_RAM_PROT  = 16'hA001;
	localparam logic [15:0] REG_IRQ_LATCH = 16'hC000;
	localparam logic [15:0] REG_IRQ_RELD  = 16'hC001;
	localparam logic [15:0] REG_IRQ_DIS   = 16'hE000;
	localparam logic [15:0] REG_IRQ_EN    = 16'hE001;
	localparam logic [15:0] EXP_SHADOW0   = 16'h5000;
	localparam logic [15:0] EXP_SETUP     = 16'h5010;
	localparam logic [15:0] EXP_LOCK      = 16'h5012;
	localparam logic [15:0] EXP_SHADOW3   = 16'h5013;
	localparam logic [15:0] RD_SHADOW0    = 16'h6000;
	localparam logic [15:0] RD_SHADOW1    = 16'h6010;
	localparam logic [15:0] RD_SHADOW2    = 16'h6012;
	localparam logic [15:0] RD_SHADOW3    = 16'h6013;
	localparam logic [7:0]  SETUP_SHADOW  = 8'h60;
	localparam logic [7:0]  KEEP_MARK     = 8'hFF;

	// Bank-bit scramble used while the protection setup flag is on.
	function automatic logic [7:0] permute_bank(input logic [2:0] r, input logic [7:0] b);
		logic [7:0] p;
		p = {b[5], b[4], b[2], b[6], b[7], b[3], b[1], b[0]};
		permute_bank = (r < 3'd2) ? b : p;
	endfunction

endpackage

// ----- sv/cartridge_bank_mapper_scanline_irq_top.sv -----
// Top level of the cartridge bank mapper with scanline interrupt counter.
// Depends on cbm_pkg and cbm_mod_unit.
//
//  channel | signals                         | direction
//  in      | in_valid, in_stall, in_word     | item in
//  out     | out_valid, out_stall, out_word  | result out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// A translate item that needs a reduction starts the bit-serial modulo unit,
// which runs 8 reduction steps before the remainder is delivered. Other items,
// and translates with a direct bank, are held in item_q and then registered
// into res_q. A new item is accepted only when no item is in work and the
// output register is empty or being taken, so output stalls add directly.
// Reset returns all mapper state to its defaults at once.
module cartridge_bank_mapper_scanline_irq_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  cbm_pkg::in_word_t in_word,
	output logic              out_valid,
	input  logic              out_stall,
	output cbm_pkg::out_word_t out_word,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [8:0]        cfg_data
);
	import cbm_pkg::*;

	logic [8:0] prg_cnt_q, chr_cnt_q;
	logic       protect_q, four_q, ram_pres_q;
	logic [7:0] bank_select_q, ram_protect_q, irq_latch_q, irq_count_q;
	logic [7:0] bank_regs_q [8];
	logic [7:0] saved_q [6];
	logic [7:0] shadow_q [4];
	logic       mirror_q, reload_q, enable_q, pending_q, lock_q, setup_q;

	state_t     state_q, state_d;
	in_word_t   item_q;
	out_word_t  res_q;
	out_word_t  res_d;
	logic       accept, out_free, start_mod;
	mod_req_t   mreq;
	mod_rsp_t   mrsp;

	logic [8:0] prg_eff, chr_eff;
	logic [1:0] pslot;
	logic [2:0] cslot;
	logic [7:0] cval;
	logic [7:0] dividend;
	logic       need_mod, direct_ok;
	logic [7:0] direct_bank;
	logic [2:0] reg_sel;
	logic [7:0] wdata;
	logic       hit;
	logic [7:0] hit_data;

	assign out_free  = !out_valid || !out_stall;
	assign in_stall  = (state_q != ST_IDLE) || !out_free;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_word  = res_q;

	// Effective bank counts.
	always_comb begin
		prg_eff = prg_cnt_q;
		if (prg_cnt_q < 9'd2) prg_eff = 9'd2;
		if (prg_cnt_q > 9'd256) prg_eff = 9'd256;
		chr_eff = (chr_cnt_q > 9'd256) ? 9'd256 : chr_cnt_q;
	end

	// Bank lookup for the held item; chooses a direct value or a reduction.
	always_comb begin
		pslot = item_q.address[14:13];
		cslot = item_q.address[12:10] ^ {bank_select_q[7], 2'b00};
		if (cslot < 3'd4) begin
			cval = bank_regs_q[{2'b00, cslot[1]}];
			cval = cslot[0] ? (cval | 8'h01) : (cval & 8'hFE);
		end else begin
			cval = bank_regs_q[cslot - 3'd2];
		end
		need_mod    = 1'b0;
		direct_bank = '0;
		dividend    = '0;
		if (item_q.kind == KIND_PRG_XLATE) begin
			if (pslot == 2'd3) direct_bank = 8'(prg_eff - 9'd1);
			else if (pslot == 2'd1) begin
				need_mod = 1'b1;
				dividend = bank_regs_q[7];
			end else if ((pslot == 2'd0) == (bank_select_q[6] == 1'b0)) begin
				need_mod = 1'b1;
				dividend = bank_regs_q[6];
			end else direct_bank = 8'(prg_eff - 9'd2);
		end else if (item_q.kind == KIND_CHR_XLATE) begin
			if (chr_cnt_q == 9'd0) direct_bank = {5'd0, item_q.address[12:10]};
			else begin
				need_mod = 1'b1;
				dividend = cval;
			end
		end
	end
	assign direct_ok = !need_mod;

	// Sequencer: idle, then deliver or start a reduction, then reduce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		start_mod = 1'b0;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_DONE;
			ST_DONE: begin
				if (need_mod) begin
					start_mod = 1'b1;
					state_d   = ST_MOD;
				end else state_d = ST_IDLE;
			end
			ST_MOD: if (mrsp.done) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign mreq.start    = start_mod;
	assign mreq.dividend = dividend;
	assign mreq.divisor  = (item_q.kind == KIND_PRG_XLATE) ? prg_eff : chr_eff;

	cbm_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	always_ff @(posedge clk) begin
		if (accept) item_q <= in_word;
	end

	// Decode helpers for writes and reads.
	always_comb begin
		reg_sel = bank_select_q[2:0];
		wdata   = item_q.data;
		if (protect_q && reg_sel <= 3'd5) begin
			if (lock_q) begin
				if (item_q.data == KEEP_MARK) wdata = saved_q[reg_sel];
			end else if (setup_q) begin
				wdata = permute_bank(reg_sel, item_q.data);
			end
		end
		hit      = 1'b0;
		hit_data = '0;
		if (protect_q && !lock_q) begin
			hit = 1'b1;
			if (item_q.address == RD_SHADOW0) hit_data = shadow_q[0];
			else if (item_q.address == RD_SHADOW1) hit_data = shadow_q[1];
			else if (item_q.address == RD_SHADOW2) hit_data = shadow_q[2];
			else if (item_q.address == RD_SHADOW3) hit_data = shadow_q[3];
			else hit = 1'b0;
		end
	end

	// Result word for the held item, as the state stands after the item.
	always_comb begin
		res_d                   = '0;
		res_d.bank_number       = direct_bank;
		res_d.irq_line          = pending_q;
		res_d.mirror_horizontal = mirror_q;
		case (item_q.kind)
			KIND_REG_WRITE: begin
				if ((item_q.address & REG_ADDR_MASK) == REG_MIRROR) begin
					res_d.mirror_horizontal = item_q.data[0];
					res_d.mirror_update     = !four_q;
				end
				if ((item_q.address & REG_ADDR_MASK) == REG_IRQ_DIS) res_d.irq_line = 1'b0;
			end
			KIND_RAM_READ: begin
				res_d.ram_offset    = item_q.address[12:0];
				res_d.read_data     = hit_data;
				res_d.read_from_ram = !hit && ram_pres_q;
			end
			KIND_SCANLINE: begin
				if (item_q.rendering_on && !reload_q && irq_count_q == 8'd1 && enable_q)
					res_d.irq_line = 1'b1;
			end
			default: ;
		endcase
	end

	// Mapper state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_cnt_q <= 9'd32; chr_cnt_q <= 9'd256;
			protect_q <= 1'b0; four_q <= 1'b0; ram_pres_q <= 1'b1;
			bank_select_q <= '0; ram_protect_q <= '0;
			irq_latch_q <= '0; irq_count_q <= '0;
			for (int i = 0; i < 8; i++) bank_regs_q[i] <= (i == 7) ? 8'd1 : 8'd0;
			for (int i = 0; i < 6; i++) saved_q[i] <= '0;
			for (int i = 0; i < 4; i++) shadow_q[i] <= '0;
			mirror_q <= 1'b0; reload_q <= 1'b0; enable_q <= 1'b0;
			pending_q <= 1'b0; lock_q <= 1'b0; setup_q <= 1'b0;
			out_valid <= 1'b0;
			res_q <= '0;
		end else begin
			if (state_q == ST_DONE) out_valid <= direct_ok;
			else if (state_q == ST_MOD && mrsp.done) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_PRG_COUNT: prg_cnt_q <= cfg_data;
					CFG_CHR_COUNT: chr_cnt_q <= cfg_data;
					CFG_PROTECT:   protect_q <= cfg_data[0];
					CFG_FOUR_SCR:  four_q <= cfg_data[0];
					CFG_RAM_PRES:  ram_pres_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (state_q == ST_MOD && mrsp.done) begin
				res_q.bank_number <= mrsp.remainder;
			end
			if (state_q == ST_DONE) begin
				res_q <= res_d;
				case (item_q.kind)
					KIND_REG_WRITE: begin
						case (item_q.address & REG_ADDR_MASK)
							REG_BANK_SEL:  bank_select_q <= item_q.data;
							REG_BANK_DATA: bank_regs_q[reg_sel] <= wdata;
							REG_MIRROR:    mirror_q <= item_q.data[0];
							REG_RAM_PROT:  ram_protect_q <= item_q.data;
							REG_IRQ_LATCH: irq_latch_q <= item_q.data;
							REG_IRQ_RELD:  reload_q <= 1'b1;
							REG_IRQ_DIS: begin
								enable_q <= 1'b0;
								pending_q <= 1'b0;
							end
							REG_IRQ_EN:    enable_q <= 1'b1;
							default: ;
						endcase
					end
					KIND_EXP_WRITE: begin
						if (protect_q) begin
							if (item_q.address == EXP_SHADOW0) shadow_q[0] <= item_q.data;
							else if (item_q.address == EXP_SETUP) begin
								if (item_q.data == 8'd0) begin
									shadow_q[1] <= SETUP_SHADOW;
									if (!lock_q) setup_q <= 1'b1;
								end
							end else if (item_q.address == EXP_LOCK) begin
								shadow_q[2] <= item_q.data;
								lock_q <= 1'b1;
								setup_q <= 1'b0;
								for (int i = 0; i < 6; i++) begin
									saved_q[i] <= bank_regs_q[i];
									bank_regs_q[i] <= '0;
								end
							end else if (item_q.address == EXP_SHADOW3) begin
								shadow_q[3] <= item_q.data;
							end
						end
					end
					KIND_SCANLINE: begin
						if (item_q.rendering_on) begin
							if (irq_count_q == 8'd0 || reload_q) begin
								irq_count_q <= irq_latch_q;
								reload_q <= 1'b0;
							end else begin
								irq_count_q <= irq_count_q - 8'd1;
								if (irq_count_q == 8'd1 && enable_q) pending_q <= 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	// ram_protect is stored but steers nothing.
	logic unused_prot;
	assign unused_prot = ^ram_protect_q;

endmodule

// ----- sv/cbm_mod_unit.sv -----
// Shared modulo unit: restoring remainder, one quotient bit per cycle.
// Depends on cbm_pkg.
module cbm_mod_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  cbm_pkg::mod_req_t req,
	output cbm_pkg::mod_rsp_t rsp
);
	import cbm_pkg::*;

	logic [8:0] rem_q;
	logic [7:0] dvd_q;
	logic [8:0] div_q;
	logic [3:0] cnt_q;
	logic       busy_q;
	logic       done_q;
	logic [9:0] trial;
	logic [9:0] diff;

	// One shift-and-subtract step.
	always_comb begin
		trial = {rem_q, dvd_q[7]};
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd8;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[6:0], 1'b0};
			rem_q <= diff[9] ? trial[8:0] : diff[8:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q[7:0];

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the cartridge bank mapper with scanline interrupt counter.
// Depends on cbm_pkg and cartridge_bank_mapper_scanline_irq_top; predicts each result word.
module tb;
	import cbm_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	in_word_t   in_word;
	logic       out_valid;
	logic       out_stall;
	out_word_t  out_word;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_index;
	logic [8:0] cfg_data;

	cartridge_bank_mapper_scanline_irq_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Mapper model state and its copy of the configuration.
	logic [8:0] m_prg_count;
	logic [8:0] m_chr_count;
	logic       m_protect;
	logic       m_four_screen;
	logic       m_ram_present;
	logic [7:0] m_bank_sel;
	logic [7:0] m_banks [8];
	logic       m_mirror;
	logic [7:0] m_ram_prot;
	logic [7:0] m_latch;
	logic [7:0] m_count;
	logic       m_reload;
	logic       m_irq_en;
	logic       m_irq_pend;
	logic       m_lock;
	logic       m_setup;
	logic [7:0] m_saved [6];
	logic [7:0] m_shadow [4];

	out_word_t  expected_words [$];
	int         errors;
	int         idle_cycles;
	bit         quiet;
	bit         done_all;

	always #5 clk = ~clk;

	// Scrambles bank bits for registers 2..5 while setup is active.
	function automatic logic [7:0] scramble_bank(input int r, input logic [7:0] b);
		if (r < 2)
			return b;
		return {b[5], b[4], b[2], b[6], b[7], b[3], b[1], b[0]};
	endfunction

	function automatic logic [7:0] prg_bank_of(input logic [15:0] a);
		int c;
		int slot;
		c = int'(m_prg_count);
		if (c < 2) c = 2;
		if (c > 256) c = 256;
		slot = int'(a[14:13]);
		if (slot == 3) return 8'(c - 1);
		if (slot == 1) return 8'(int'(m_banks[7]) % c);
		if ((slot == 0) == (m_bank_sel[6] == 1'b0)) return 8'(int'(m_banks[6]) % c);
		return 8'(c - 2);
	endfunction

	function automatic logic [7:0] chr_bank_of(input logic [15:0] a);
		int c;
		int slot;
		int v;
		c = int'(m_chr_count);
		slot = int'(a[12:10]);
		if (c == 0) return 8'(slot);
		if (c > 256) c = 256;
		if (m_bank_sel[7]) slot = slot ^ 4;
		if (slot < 4) begin
			v = int'(m_banks[slot >> 1]);
			v = (slot & 1) ? (v | 1) : (v & 8'hFE);
		end else begin
			v = int'(m_banks[slot - 2]);
		end
		return 8'(v % c);
	endfunction

	task automatic model_reset();
		m_prg_count = 32;
		m_chr_count = 256;
		m_protect = 0;
		m_four_screen = 0;
		m_ram_present = 1;
		m_bank_sel = 0;
		foreach (m_banks[i]) m_banks[i] = 0;
		m_banks[7] = 1;
		m_mirror = 0;
		m_ram_prot = 0;
		m_latch = 0;
		m_count = 0;
		m_reload = 0;
		m_irq_en = 0;
		m_irq_pend = 0;
		m_lock = 0;
		m_setup = 0;
		foreach (m_saved[i]) m_saved[i] = 0;
		foreach (m_shadow[i]) m_shadow[i] = 0;
	endtask

	// Applies one item to the model and returns the word the block should produce.
	function automatic out_word_t apply_bus_event(input in_word_t w);
		out_word_t r;
		logic [7:0] d;
		int reg_i;
		bit hit;
		r = '0;
		d = w.data;
		case (w.kind)
			KIND_REG_WRITE: begin
				case (w.address & REG_ADDR_MASK)
					REG_BANK_SEL: m_bank_sel = d;
					REG_BANK_DATA: begin
						reg_i = int'(m_bank_sel[2:0]);
						if (m_protect && reg_i <= 5) begin
							if (m_lock) begin
								if (d == KEEP_MARK) d = m_saved[reg_i];
							end else if (m_setup) begin
								d = scramble_bank(reg_i, d);
							end
						end
						m_banks[reg_i] = d;
					end
					REG_MIRROR: begin
						m_mirror = d[0];
						if (!m_four_screen) r.mirror_update = 1;
					end
					REG_RAM_PROT: m_ram_prot = d;
					REG_IRQ_LATCH: m_latch = d;
					REG_IRQ_RELD: m_reload = 1;
					REG_IRQ_DIS: begin
						m_irq_en = 0;
						m_irq_pend = 0;
					end
					REG_IRQ_EN: m_irq_en = 1;
					default: ;
				endcase
			end
			KIND_EXP_WRITE: begin
				if (m_protect) begin
					if (w.address == EXP_SHADOW0) begin
						m_shadow[0] = d;
					end else if (w.address == EXP_SETUP) begin
						if (d == 0) begin
							m_shadow[1] = SETUP_SHADOW;
							if (!m_lock) m_setup = 1;
						end
					end else if (w.address == EXP_LOCK) begin
						m_shadow[2] = d;
						m_lock = 1;
						m_setup = 0;
						for (int i = 0; i < 6; i++) begin
							m_saved[i] = m_banks[i];
							m_banks[i] = 0;
						end
					end else if (w.address == EXP_SHADOW3) begin
						m_shadow[3] = d;
					end
				end
			end
			KIND_RAM_READ: begin
				hit = 0;
				r.ram_offset = w.address[12:0];
				if (m_protect && !m_lock) begin
					hit = 1;
					if (w.address == RD_SHADOW0) r.read_data = m_shadow[0];
					else if (w.address == RD_SHADOW1) r.read_data = m_shadow[1];
					else if (w.address == RD_SHADOW2) r.read_data = m_shadow[2];
					else if (w.address == RD_SHADOW3) r.read_data = m_shadow[3];
					else hit = 0;
				end
				if (!hit && m_ram_present) r.read_from_ram = 1;
			end
			KIND_SCANLINE: begin
				if (w.rendering_on) begin
					if (m_count == 0 || m_reload) begin
						m_count = m_latch;
						m_reload = 0;
					end else begin
						m_count = 8'(m_count - 8'd1);
						if (m_count == 0 && m_irq_en) m_irq_pend = 1;
					end
				end
			end
			KIND_PRG_XLATE: r.bank_number = prg_bank_of(w.address);
			KIND_CHR_XLATE: r.bank_number = chr_bank_of(w.address);
			default: ;
		endcase
		r.irq_line = m_irq_pend;
		r.mirror_horizontal = m_mirror;
		return r;
	endfunction

	// Sends one word, with an occasional gap before it. Valid drops
	// after each accept, while the block is busy and stalls anyway.
	task automatic send_word(input in_word_t w);
		if (!quiet && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) @(posedge clk);
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_words.push_back(apply_bus_event(w));
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send(input logic [2:0] k, input logic [15:0] a, input logic [7:0] d,
			input logic ren = 1'b1);
		in_word_t w;
		w.kind = k;
		w.address = a;
		w.data = d;
		w.rendering_on = ren;
		send_word(w);
	endtask

	task automatic drain();
		while (expected_words.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// Writes one configuration register; the block must be idle.
	task automatic write_cfg(input cfg_idx_t idx, input logic [8:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_PRG_COUNT: m_prg_count = v;
			CFG_CHR_COUNT: m_chr_count = v;
			CFG_PROTECT: m_protect = v[0];
			CFG_FOUR_SCR: m_four_screen = v[0];
			CFG_RAM_PRES: m_ram_present = v[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Result checker with random output stall.
	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, out_word);
				errors++;
			end else begin
				e = expected_words.pop_front();
				if (out_word.bank_number !== e.bank_number)
					$display("%0t: bank_number expected %h actual %h", $time,
						e.bank_number, out_word.bank_number);
				if (out_word.read_data !== e.read_data)
					$display("%0t: read_data expected %h actual %h", $time,
						e.read_data, out_word.read_data);
				if (out_word.read_from_ram !== e.read_from_ram)
					$display("%0t: read_from_ram expected %b actual %b", $time,
						e.read_from_ram, out_word.read_from_ram);
				if (out_word.ram_offset !== e.ram_offset)
					$display("%0t: ram_offset expected %h actual %h", $time,
						e.ram_offset, out_word.ram_offset);
				if (out_word.irq_line !== e.irq_line)
					$display("%0t: irq_line expected %b actual %b", $time,
						e.irq_line, out_word.irq_line);
				if (out_word.mirror_horizontal !== e.mirror_horizontal)
					$display("%0t: mirror_horizontal expected %b actual %b", $time,
						e.mirror_horizontal, out_word.mirror_horizontal);
				if (out_word.mirror_update !== e.mirror_update)
					$display("%0t: mirror_update expected %b actual %b", $time,
						e.mirror_update, out_word.mirror_update);
				if (out_word !== e) errors++;
			end
		end
		if (!quiet && $urandom_range(0, 4) == 0)
			out_stall <= 1'b1;
		else if (quiet || $urandom_range(0, 1) == 0)
			out_stall <= 1'b0;
	end

	// Watchdog on cycles with no accepted word.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000 && !done_all) begin
			$display("tb failed");
			$finish;
		end
	end

	// Returns a random address biased toward the decoded registers and ports.
	function automatic logic [15:0] pick_address(input logic [2:0] k);
		logic [15:0] a;
		a = 16'($urandom);
		case (k)
			KIND_REG_WRITE: if ($urandom_range(0, 7) != 0)
				a = {$urandom_range(4, 7) == 4 ? 3'b100 : 3'($urandom_range(4, 7)),
					a[12:1], 1'($urandom)};
			KIND_EXP_WRITE: if ($urandom_range(0, 3) != 0)
				case ($urandom_range(0, 3))
					0: a = EXP_SHADOW0;
					1: a = EXP_SETUP;
					2: a = EXP_LOCK;
					default: a = EXP_SHADOW3;
				endcase
			KIND_RAM_READ: if ($urandom_range(0, 2) != 0)
				case ($urandom_range(0, 3))
					0: a = RD_SHADOW0;
					1: a = RD_SHADOW1;
					2: a = RD_SHADOW2;
					default: a = RD_SHADOW3;
				endcase
			default: ;
		endcase
		return a;
	endfunction

	task automatic random_items(input int n);
		logic [2:0] k;
		logic [7:0] d;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99) < 2 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
			d = 8'($urandom);
			if (k == KIND_EXP_WRITE && $urandom_range(0, 1) == 0) d = 0;
			if (k == KIND_REG_WRITE && $urandom_range(0, 5) == 0) d = KEEP_MARK;
			send(k, pick_address(k), d, $urandom_range(0, 5) != 0);
		end
	endtask

	// Directed: every kind, register decode and field extremes.
	task automatic test_directed();
		send(KIND_PRG_XLATE, 16'h0000, 0);
		send(KIND_PRG_XLATE, 16'hFFFF, 8'hFF);
		send(KIND_CHR_XLATE, 16'hFFFF, 0);
		send(KIND_REG_WRITE, 16'h7FFF, 8'hFF);
		send(KIND_REG_WRITE, REG_BANK_SEL, 8'hC7);
		send(KIND_REG_WRITE, REG_BANK_DATA, 8'hFF);
		send(KIND_PRG_XLATE, 16'h2000, 0);
		send(KIND_CHR_XLATE, 16'h0400, 0);
		send(KIND_REG_WRITE, REG_MIRROR, 8'h01);
		send(KIND_REG_WRITE, REG_RAM_PROT, 8'h80);
		send(KIND_REG_WRITE, REG_IRQ_LATCH, 8'h02);
		send(KIND_REG_WRITE, REG_IRQ_RELD, 0);
		send(KIND_REG_WRITE, REG_IRQ_EN, 0);
		repeat (4) send(KIND_SCANLINE, 0, 0, 1);
		send(KIND_SCANLINE, 0, 0, 0);
		send(KIND_REG_WRITE, REG_IRQ_DIS, 0);
		send(KIND_EXP_WRITE, EXP_SHADOW0, 8'h55);
		send(KIND_RAM_READ, 16'hFFFF, 0);
		send(3'd6, 16'hFFFF, 8'hFF);
		send(3'd7, 16'h8000, 8'hFF);
	endtask

	// Protection variant: setup, scrambled writes, lock and readback.
	task automatic test_protection();
		drain();
		write_cfg(CFG_PROTECT, 1);
		write_cfg(CFG_RAM_PRES, 0);
		write_cfg(CFG_FOUR_SCR, 1);
		send(KIND_EXP_WRITE, EXP_SHADOW0, 8'hA5);
		send(KIND_EXP_WRITE, EXP_SETUP, 0);
		send(KIND_RAM_READ, RD_SHADOW1, 0);
		for (int r = 0; r < 8; r++) begin
			send(KIND_REG_WRITE, REG_BANK_SEL, 8'(r));
			send(KIND_REG_WRITE, REG_BANK_DATA, 8'($urandom));
		end
		send(KIND_EXP_WRITE, EXP_LOCK, 8'h3C);
		send(KIND_EXP_WRITE, EXP_SHADOW3, 8'h99);
		send(KIND_RAM_READ, RD_SHADOW0, 0);
		send(KIND_REG_WRITE, REG_BANK_SEL, 2);
		send(KIND_REG_WRITE, REG_BANK_DATA, KEEP_MARK);
		send(KIND_REG_WRITE, REG_MIRROR, 0);
		random_items(350);
	endtask

	// Random phases across bank count settings, extremes included.
	task automatic test_bank_counts();
		int prg_vals [6] = '{0, 1, 2, 256, 511, 37};
		int chr_vals [6] = '{0, 256, 511, 1, 8, 100};
		for (int p = 0; p < 6; p++) begin
			drain();
			write_cfg(CFG_PRG_COUNT, 9'(prg_vals[p]));
			write_cfg(CFG_CHR_COUNT, 9'(chr_vals[p]));
			write_cfg(CFG_PROTECT, {8'd0, p[0]});
			write_cfg(CFG_FOUR_SCR, {8'd0, p[1]});
			write_cfg(CFG_RAM_PRES, {8'd0, p[2] ^ 1'b1});
			random_items(130);
		end
	endtask

	// Sender holds off until every result has come back.
	task automatic test_holdoff();
		drain();
		random_items(40);
		while (expected_words.size() != 0) @(posedge clk);
		random_items(40);
	endtask

	// Final part with no idling on either side.
	task automatic test_full_rate();
		drain();
		write_cfg(CFG_PRG_COUNT, 9'd64);
		write_cfg(CFG_CHR_COUNT, 9'd128);
		quiet = 1;
		random_items(200);
	endtask

	initial begin
		clk = 0;
		arst_n = 0;
		in_valid = 0;
		in_word = '0;
		out_stall = 0;
		cfg_valid = 0;
		cfg_index = CFG_PRG_COUNT;
		cfg_data = '0;
		errors = 0;
		idle_cycles = 0;
		quiet = 0;
		done_all = 0;
		model_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_protection();
		test_bank_counts();
		test_holdoff();
		test_full_rate();
		while (expected_words.size() != 0) @(posedge clk);
		done_all = 1;
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_words.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule

// ----- filelist.f -----
sv/cbm_pkg.sv
sv/cbm_mod_unit.sv
sv/cartridge_bank_mapper_scanline_irq_top.sv
tb/tb.sv
